/* sv/aps_pkg.sv */
`timescale 1ns / 1ps

package aps_pkg;

   // number of free-text description bytes in the patch header
   localparam int DESCRIPTION_LENGTH = 50;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 64;

   // configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_SWAPPED   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_CART_ID   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_TERRITORY = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_CRC       = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_IMAGE_SIZE      = 3'd4;

   typedef enum logic [3:0] {
      PH_MAGIC  = 4'd0,
      PH_TYPE   = 4'd1,
      PH_ENC    = 4'd2,
      PH_DESC   = 4'd3,
      PH_FORMAT = 4'd4,
      PH_CART   = 4'd5,
      PH_TERR   = 4'd6,
      PH_CRC    = 4'd7,
      PH_PAD    = 4'd8,
      PH_SIZE   = 4'd9,
      PH_OFFSET = 4'd10,
      PH_COUNT  = 4'd11,
      PH_DATA   = 4'd12,
      PH_FVAL   = 4'd13,
      PH_FLEN   = 4'd14
   } phase_type;

   typedef enum logic [3:0] {
      EV_WRITE  = 4'd0,
      EV_FILL   = 4'd1,
      EV_RESIZE = 4'd2,
      EV_TERR   = 4'd3,
      EV_CRC    = 4'd4,
      EV_MAGIC  = 4'd5,
      EV_TYPE   = 4'd6,
      EV_ENC    = 4'd7,
      EV_FORMAT = 4'd8,
      EV_CART   = 4'd9,
      EV_TRUNC  = 4'd10,
      EV_OFFSET = 4'd11
   } event_type;

   typedef struct packed {
      logic [7:0] patch_byte;
      logic       end_of_patch;
   } req_type;

   typedef struct packed {
      logic [3:0]  event_res;
      logic [31:0] address;
      logic [7:0]  value;
      logic [7:0]  run_length;
      logic [31:0] new_size;
   } rsp_type;

   typedef struct packed {
      logic        image_swapped;
      logic [15:0] image_cart_id;
      logic [15:0] image_territory_pair;
      logic [63:0] image_crc;
      logic [31:0] image_size;
   } cfg_type;

   typedef struct packed {
      phase_type   phase;
      logic [6:0]  header_position;
      logic [31:0] offset_accumulator;
      logic [7:0]  bytes_remaining;
      logic [7:0]  fill_value;
      logic [31:0] next_address;
      logic        magic_mismatch;
      logic        crc_mismatch;
      logic        rejected;
   } parse_state_type;

   // result of one parse step
   typedef struct packed {
      parse_state_type state;
      logic            push;
      rsp_type         rsp;
   } step_type;

   // "APS10"
   function automatic logic [7:0] magic_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = 8'h41;
         3'd1:    b = 8'h50;
         3'd2:    b = 8'h53;
         3'd3:    b = 8'h31;
         3'd4:    b = 8'h30;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

/* sv/aps_patch_stream_applier.sv */
`timescale 1ns / 1ps

// patch stream applier: parses a patch file one byte per req beat and turns
// it into write / fill / resize commands and header warnings or errors
//   req channel : req_data carries patch_byte and end_of_patch; a beat moves
//                 when req_valid is high and req_stall is low
//   rsp channel : zero or one rsp beat per req beat, in order; event_res names
//                 the event, other fields are zero where they do not apply
//   csr port    : csr_we writes register csr_index with csr_data (low bits
//                 used); write only while the block is idle
// result: registered, on rsp_valid the cycle after its req beat unless earlier
//   results wait; throughput: one patch byte per cycle while req_stall is low;
//   the parse step is a single pass from the parse state to the result register
// stall: results queue in a two-entry output buffer; req_stall rises only
//   when both entries hold results, so one result can wait on a stalled
//   receiver without blocking input
// reset: synchronous, clears parse state, registers and the output buffer;
//   the block is ready for a patch header in the next cycle
// after a fatal error all bytes up to end_of_patch give no result; the beat
//   with end_of_patch returns the parser to the header phase
module aps_patch_stream_applier import aps_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_type                    rsp_data,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   cfg_type         cfg_ff, cfg_in;
   parse_state_type state_ff, state_in;
   step_type        step;
   logic            accept;
   logic            buf_full;

   // config registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_SWAPPED:   cfg_in.image_swapped        = csr_data[0];
            CSR_IMAGE_CART_ID:   cfg_in.image_cart_id        = csr_data[15:0];
            CSR_IMAGE_TERRITORY: cfg_in.image_territory_pair = csr_data[15:0];
            CSR_IMAGE_CRC:       cfg_in.image_crc            = csr_data;
            CSR_IMAGE_SIZE:      cfg_in.image_size           = csr_data[31:0];
            default:             ; // writes beyond the register list are dropped
         endcase
      end
   end

   // one parse step per accepted byte
   aps_step u_step (
      .cur  (state_ff),
      .req  (req_data),
      .cfg  (cfg_ff),
      .step (step)
   );

   assign accept   = req_valid && !req_stall;
   assign state_in = accept ? step.state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= '0;
         state_ff <= '{phase:              PH_MAGIC,
                       header_position:    '0,
                       offset_accumulator: '0,
                       bytes_remaining:    '0,
                       fill_value:         '0,
                       next_address:       '0,
                       magic_mismatch:     1'b0,
                       crc_mismatch:       1'b0,
                       rejected:           1'b0};
      end else begin
         cfg_ff   <= cfg_in;
         state_ff <= state_in;
      end
   end

   // result register with skid entry
   aps_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && step.push),
      .push_data (step.rsp),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign req_stall = buf_full;

endmodule

/* sv/aps_step.sv */
`timescale 1ns / 1ps

module aps_step import aps_pkg::*; (
   input  parse_state_type cur,
   input  req_type         req,
   input  cfg_type         cfg,
   output step_type        step
);

   always_comb begin
      parse_state_type nxt;
      logic            ev_valid;
      event_type       ev;
      logic [31:0]     addr;
      logic [7:0]      val;
      logic [7:0]      run;
      logic [31:0]     nsize;
      logic [7:0]      b;
      logic            sw;
      logic [7:0]      expect_byte;
      logic [2:0]      crc_idx;
      logic [31:0]     acc;

      nxt         = cur;
      ev_valid    = 1'b0;
      ev          = EV_WRITE;
      addr        = '0;
      val         = '0;
      run         = '0;
      nsize       = '0;
      b           = req.patch_byte;
      sw          = cfg.image_swapped;
      expect_byte = '0;
      crc_idx     = sw ? (cur.header_position[2:0] ^ 3'd1) : cur.header_position[2:0];
      acc         = cur.offset_accumulator
                    | ({24'd0, b} << {cur.header_position[1:0], 3'b000});

      if (!cur.rejected) begin
         unique case (cur.phase)
            PH_MAGIC: begin
               if (b != magic_byte(cur.header_position[2:0])) nxt.magic_mismatch = 1'b1;
               if (cur.header_position >= 7'd4) begin
                  if (nxt.magic_mismatch) begin
                     ev_valid = 1'b1;
                     ev       = EV_MAGIC;
                  end
                  nxt.magic_mismatch  = 1'b0;
                  nxt.header_position = '0;
                  nxt.phase           = PH_TYPE;
               end else begin
                  nxt.header_position = cur.header_position + 7'd1;
               end
            end
            PH_TYPE: begin
               if (b != 8'd1) begin
                  ev_valid = 1'b1;
                  ev       = EV_TYPE;
               end
               nxt.phase = PH_ENC;
            end
            PH_ENC: begin
               if (b != 8'd0) begin
                  ev_valid = 1'b1;
                  ev       = EV_ENC;
               end
               nxt.header_position = '0;
               nxt.phase           = PH_DESC;
            end
            PH_DESC: begin
               if (cur.header_position >= 7'(DESCRIPTION_LENGTH - 1)) begin
                  nxt.header_position = '0;
                  nxt.phase           = PH_FORMAT;
               end else begin
                  nxt.header_position = cur.header_position + 7'd1;
               end
            end
            PH_FORMAT: begin
               if ((sw && b == 8'd1) || (!sw && b == 8'd0)) begin
                  ev_valid = 1'b1;
                  ev       = EV_FORMAT;
               end
               nxt.header_position = '0;
               nxt.phase           = PH_CART;
            end
            PH_CART: begin
               // swapped image sees the low byte of the cart id first
               if ((cur.header_position == 7'd0) != sw) expect_byte = cfg.image_cart_id[15:8];
               else                                     expect_byte = cfg.image_cart_id[7:0];
               if (b != expect_byte) nxt.magic_mismatch = 1'b1;
               if (cur.header_position >= 7'd1) begin
                  if (nxt.magic_mismatch) begin
                     ev_valid = 1'b1;
                     ev       = EV_CART;
                  end
                  nxt.magic_mismatch  = 1'b0;
                  nxt.header_position = '0;
                  nxt.phase           = PH_TERR;
               end else begin
                  nxt.header_position = cur.header_position + 7'd1;
               end
            end
            PH_TERR: begin
               expect_byte = sw ? cfg.image_territory_pair[7:0]
                                : cfg.image_territory_pair[15:8];
               if (b != expect_byte) begin
                  ev_valid = 1'b1;
                  ev       = EV_TERR;
               end
               nxt.header_position = '0;
               nxt.phase           = PH_CRC;
            end
            PH_CRC: begin
               expect_byte = cfg.image_crc[{~crc_idx, 3'b000} +: 8];
               if (b != expect_byte) nxt.crc_mismatch = 1'b1;
               if (cur.header_position >= 7'd7) begin
                  if (nxt.crc_mismatch) begin
                     ev_valid = 1'b1;
                     ev       = EV_CRC;
                  end
                  nxt.crc_mismatch    = 1'b0;
                  nxt.header_position = '0;
                  nxt.phase           = PH_PAD;
               end else begin
                  nxt.header_position = cur.header_position + 7'd1;
               end
            end
            PH_PAD: begin
               if (cur.header_position >= 7'd4) begin
                  nxt.header_position    = '0;
                  nxt.offset_accumulator = '0;
                  nxt.phase              = PH_SIZE;
               end else begin
                  nxt.header_position = cur.header_position + 7'd1;
               end
            end
            PH_SIZE: begin
               nxt.offset_accumulator = acc;
               if (cur.header_position >= 7'd3) begin
                  if (acc != cfg.image_size) begin
                     ev_valid = 1'b1;
                     ev       = EV_RESIZE;
                     nsize    = acc;
                  end
                  nxt.offset_accumulator = '0;
                  nxt.header_position    = '0;
                  nxt.phase              = PH_OFFSET;
               end else begin
                  nxt.header_position = cur.header_position + 7'd1;
               end
            end
            PH_OFFSET: begin
               nxt.offset_accumulator = acc;
               if (cur.header_position >= 7'd3) begin
                  if (acc[31]) begin
                     ev_valid = 1'b1;
                     ev       = EV_OFFSET;
                     addr     = acc;
                  end else begin
                     nxt.next_address = acc;
                  end
                  nxt.offset_accumulator = '0;
                  nxt.header_position    = '0;
                  nxt.phase              = PH_COUNT;
               end else begin
                  nxt.header_position = cur.header_position + 7'd1;
               end
            end
            PH_COUNT: begin
               if (b != 8'd0) begin
                  nxt.bytes_remaining = b;
                  nxt.phase           = PH_DATA;
               end else begin
                  nxt.phase = PH_FVAL;
               end
            end
            PH_DATA: begin
               ev_valid            = 1'b1;
               ev                  = EV_WRITE;
               addr                = cur.next_address;
               val                 = b;
               nxt.next_address    = cur.next_address + 32'd1;
               nxt.bytes_remaining = cur.bytes_remaining - 8'd1;
               if (nxt.bytes_remaining == 8'd0) nxt.phase = PH_OFFSET;
            end
            PH_FVAL: begin
               nxt.fill_value = b;
               nxt.phase      = PH_FLEN;
            end
            PH_FLEN: begin
               ev_valid  = 1'b1;
               ev        = EV_FILL;
               addr      = cur.next_address;
               val       = cur.fill_value;
               run       = b;
               nxt.phase = PH_OFFSET;
            end
            default: begin
               nxt.phase           = PH_OFFSET;
               nxt.header_position = '0;
            end
         endcase

         // fatal events win; otherwise a short last byte reports truncation
         if (ev_valid && ev >= EV_MAGIC) begin
            nxt.rejected = 1'b1;
         end else if (req.end_of_patch
                      && !(nxt.phase == PH_OFFSET && nxt.header_position == 7'd0)) begin
            ev_valid = 1'b1;
            ev       = EV_TRUNC;
            addr     = '0;
            val      = '0;
            run      = '0;
            nsize    = '0;
         end
      end

      if (req.end_of_patch) begin
         nxt       = '0;
         nxt.phase = PH_MAGIC;
      end

      step.state          = nxt;
      step.push           = ev_valid;
      step.rsp.event_res  = ev;
      step.rsp.address    = addr;
      step.rsp.value      = val;
      step.rsp.run_length = run;
      step.rsp.new_size   = nsize;
   end

endmodule

/* sv/aps_rsp_buf.sv */
`timescale 1ns / 1ps

module aps_rsp_buf import aps_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    take;

   assign take = main_valid_ff && !rsp_stall;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = push_data;
            main_valid_in = push;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

endmodule
